FILE: design/bfifs_pkg.sv
package bfifs_pkg;

  // Width of the screen size registers
  localparam int CFG_W = 13;

  // Entries in each of the two internal queues
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_addr_e;

  // Affine map selected for one step
  typedef enum logic [1:0] {
    MAP_STEM  = 2'd0,
    MAP_FROND = 2'd1,
    MAP_LEFT  = 2'd2,
    MAP_RIGHT = 2'd3
  } map_e;

endpackage

FILE: design/bfifs_fifo.sv
module bfifs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: design/bfifs_front.sv
module bfifs_front import bfifs_pkg::*; #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   push_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   cq_full_i,
  output logic                   full_o,
  output logic                   cq_wr_o,
  output map_e                   idx_o
);

  // sample * 100 needs seven more bits than the sample
  localparam int SW        = SAMPLE_BITS + 7;
  localparam int PCT_SCALE = 100;
  localparam int PCT_STEM  = 1;
  localparam int PCT_FROND = 86;
  localparam int PCT_LEFT  = 93;

  localparam logic [SW-1:0] TH_STEM  = SW'(PCT_STEM) << SAMPLE_BITS;
  localparam logic [SW-1:0] TH_FROND = SW'(PCT_FROND) << SAMPLE_BITS;
  localparam logic [SW-1:0] TH_LEFT  = SW'(PCT_LEFT) << SAMPLE_BITS;

  logic [SW-1:0] scaled;

  assign full_o  = cq_full_i;
  assign cq_wr_o = push_i && !cq_full_i;
  assign scaled  = SW'(sample_i) * SW'(PCT_SCALE);

  // Exact percentage thresholds pick the map
  always_comb begin
    if (scaled < TH_STEM) begin
      idx_o = MAP_STEM;
    end else if (scaled < TH_FROND) begin
      idx_o = MAP_FROND;
    end else if (scaled < TH_LEFT) begin
      idx_o = MAP_LEFT;
    end else begin
      idx_o = MAP_RIGHT;
    end
  end

endmodule

FILE: design/bfifs_div.sv
module bfifs_div #(
  parameter int               NUM_W = 37,
  parameter int               DEN_W = 17,
  parameter int               Q_W   = 12,
  parameter logic [DEN_W-1:0] DEN   = 17'd1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  output logic             done_o,
  output logic [Q_W-1:0]   quot_o,
  output logic             ovf_o
);

  localparam int XW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

  // Dividends below DEN << Q_W fit in K_W bits; a shift of K_W + DEN_W
  // makes the rounded-up reciprocal exact over that whole range
  localparam int     K_W     = DEN_W + Q_W;
  localparam int     SHIFT   = K_W + DEN_W;
  localparam longint RECIP   = ((longint'(1) << SHIFT) + longint'(DEN) - 1) / longint'(DEN);
  localparam int     RECIP_W = $clog2(RECIP + 1);
  localparam int     PROD_W  = K_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);

  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    quot_q;
  logic              ovf_q;
  logic              done_q;

  assign prod   = PROD_W'(dividend_i[K_W-1:0]) * PROD_W'(RECIP_K);
  assign done_o = done_q;
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

  // Result is ready in the cycle after start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  // Division by a constant through a reciprocal multiply
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= prod[SHIFT +: Q_W];
      ovf_q  <= (XW'(dividend_i) >= (XW'(DEN) << Q_W));
    end
  end

endmodule

FILE: design/bfifs_back.sv
module bfifs_back import bfifs_pkg::*; #(
  parameter int FRAC_BITS  = 16,
  parameter int PIXEL_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_addr_e             cfg_addr_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  cq_empty_i,
  input  map_e                  cq_idx_i,
  output logic                  cq_pop_o,
  input  logic                  oq_full_i,
  output logic                  oq_push_o,
  output logic [PIXEL_BITS-1:0] col_o,
  output logic [PIXEL_BITS-1:0] row_o,
  output map_e                  idx_o
);

  localparam int PW     = FRAC_BITS + 8;
  localparam int TERM_W = FRAC_BITS + 23;
  localparam int MULT_W = TERM_W + CFG_W + 1;
  localparam int NUM_W  = MULT_W - FRAC_BITS;
  localparam int COEF_W = FRAC_BITS + 2;
  localparam int PROD_W = COEF_W + PW;
  localparam int SUM_W  = PROD_W + 1;
  localparam int SHR_W  = SUM_W - FRAC_BITS;
  localparam int NEXT_W = SHR_W + 1;
  localparam int EW     = (CFG_W > PIXEL_BITS) ? CFG_W : PIXEL_BITS;
  localparam int DEN_W  = 17;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(500);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(500);

  // Screen mapping: x offset 2.182, spans 4.8378 and 9.9983, all scaled by 1e4
  localparam logic signed [TERM_W-1:0] K_SCALE   = TERM_W'(10000);
  localparam logic signed [TERM_W-1:0] K_COL_OFS = TERM_W'(longint'(21820) << FRAC_BITS);
  localparam logic signed [TERM_W-1:0] K_ROW_OFS = TERM_W'(longint'(99983) << FRAC_BITS);
  localparam logic [DEN_W-1:0]         COL_DEN   = DEN_W'(48378);
  localparam logic [DEN_W-1:0]         ROW_DEN   = DEN_W'(99983);

  localparam logic signed [SUM_W-1:0]  K_HALF = SUM_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [NEXT_W-1:0] PT_MAX = NEXT_W'((longint'(1) << (PW - 1)) - 1);
  localparam logic signed [NEXT_W-1:0] PT_MIN = NEXT_W'(-(longint'(1) << (PW - 1)));
  localparam logic [EW-1:0]            PIX_MAX = EW'((longint'(1) << PIXEL_BITS) - 1);

  // Hundredths to fixed point, rounded to nearest
  function automatic logic signed [COEF_W-1:0] fx(input int h);
    longint mag;
    longint v;
    mag = (h < 0) ? -longint'(h) : longint'(h);
    v   = ((mag << FRAC_BITS) + 50) / 100;
    return COEF_W'((h < 0) ? -v : v);
  endfunction

  localparam logic signed [COEF_W-1:0] C_ZERO = '0;
  localparam logic signed [COEF_W-1:0] C_P016 = fx(16);
  localparam logic signed [COEF_W-1:0] C_P085 = fx(85);
  localparam logic signed [COEF_W-1:0] C_P004 = fx(4);
  localparam logic signed [COEF_W-1:0] C_N004 = fx(-4);
  localparam logic signed [COEF_W-1:0] C_P020 = fx(20);
  localparam logic signed [COEF_W-1:0] C_N026 = fx(-26);
  localparam logic signed [COEF_W-1:0] C_P023 = fx(23);
  localparam logic signed [COEF_W-1:0] C_P022 = fx(22);
  localparam logic signed [COEF_W-1:0] C_N015 = fx(-15);
  localparam logic signed [COEF_W-1:0] C_P028 = fx(28);
  localparam logic signed [COEF_W-1:0] C_P026 = fx(26);
  localparam logic signed [COEF_W-1:0] C_P024 = fx(24);
  localparam logic signed [COEF_W-1:0] C_P160 = fx(160);
  localparam logic signed [COEF_W-1:0] C_P044 = fx(44);

  function automatic logic signed [PW-1:0] sat_pt(input logic signed [NEXT_W-1:0] v);
    if (v > PT_MAX) begin
      return PW'(PT_MAX);
    end else if (v < PT_MIN) begin
      return PW'(PT_MIN);
    end
    return PW'(v);
  endfunction

  // Final pixel: clamp at zero, at size - 1 and at the pixel range
  function automatic logic [PIXEL_BITS-1:0] pix_clip(input logic [CFG_W-1:0] size,
                                                     input logic neg, input logic ovf,
                                                     input logic [PIXEL_BITS-1:0] q);
    logic [CFG_W-1:0] sm1;
    logic [EW-1:0]    lim;
    sm1 = size - 1'b1;
    lim = (EW'(sm1) > PIX_MAX) ? PIX_MAX : EW'(sm1);
    if (size == '0 || neg) begin
      return '0;
    end else if (ovf || (EW'(q) > lim)) begin
      return lim[PIXEL_BITS-1:0];
    end
    return q;
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_TERM  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_START = 5'b01000,
    ST_DIV   = 5'b10000
  } state_e;

  state_e                     state_q;
  map_e                       idx_q;
  logic [CFG_W-1:0]           width_q, height_q;
  logic signed [PW-1:0]       point_x_q, point_y_q;
  logic signed [TERM_W-1:0]   col_term, row_term, col_term_q, row_term_q;
  logic signed [PROD_W-1:0]   ax_q, by_q, cx_q, dy_q;
  logic signed [MULT_W-1:0]   col_prod_q, row_prod_q;
  logic signed [COEF_W-1:0]   coef_a, coef_b, coef_c, coef_d, coef_f;
  logic signed [SUM_W-1:0]    sum_x, sum_y;
  logic signed [NEXT_W-1:0]   next_x, next_y;
  logic                       div_start;
  logic                       col_done, row_done, col_ovf, row_ovf;
  logic [PIXEL_BITS-1:0]      col_q, row_q;

  // Map coefficient decoder
  always_comb begin
    coef_a = C_ZERO;
    coef_b = C_ZERO;
    coef_c = C_ZERO;
    coef_d = C_ZERO;
    coef_f = C_ZERO;
    unique case (idx_q)
      MAP_STEM: begin
        coef_d = C_P016;
      end
      MAP_FROND: begin
        coef_a = C_P085;
        coef_b = C_P004;
        coef_c = C_N004;
        coef_d = C_P085;
        coef_f = C_P160;
      end
      MAP_LEFT: begin
        coef_a = C_P020;
        coef_b = C_N026;
        coef_c = C_P023;
        coef_d = C_P022;
        coef_f = C_P160;
      end
      MAP_RIGHT: begin
        coef_a = C_N015;
        coef_b = C_P028;
        coef_c = C_P026;
        coef_d = C_P024;
        coef_f = C_P044;
      end
    endcase
  end

  // Screen terms of the current point, scaled by 1e4
  assign col_term = TERM_W'(point_x_q) * K_SCALE + K_COL_OFS;
  assign row_term = K_ROW_OFS - TERM_W'(point_y_q) * K_SCALE;

  // Next point: round the Q.2F sum to Q.F, add offset, saturate
  assign sum_x  = SUM_W'(ax_q) + SUM_W'(by_q) + K_HALF;
  assign sum_y  = SUM_W'(cx_q) + SUM_W'(dy_q) + K_HALF;
  assign next_x = NEXT_W'($signed(sum_x[SUM_W-1:FRAC_BITS]));
  assign next_y = NEXT_W'($signed(sum_y[SUM_W-1:FRAC_BITS])) + NEXT_W'(coef_f);

  assign cq_pop_o  = (state_q == ST_IDLE) && !cq_empty_i && !oq_full_i;
  assign div_start = (state_q == ST_START);
  assign oq_push_o = (state_q == ST_DIV) && col_done && row_done;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cq_pop_o) begin
            state_q <= ST_TERM;
          end
        end
        ST_TERM:  state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_START;
        ST_START: state_q <= ST_DIV;
        ST_DIV: begin
          if (oq_push_o) begin
            state_q <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // Point state, updated once per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_x_q <= '0;
      point_y_q <= '0;
    end else if (state_q == ST_MUL) begin
      point_x_q <= sat_pt(next_x);
      point_y_q <= sat_pt(next_y);
    end
  end

  // Screen size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_wdata_i;
      endcase
    end
  end

  // Datapath registers, one multiply level per cycle
  always_ff @(posedge clk_i) begin
    if (cq_pop_o) begin
      idx_q <= cq_idx_i;
    end
    if (state_q == ST_TERM) begin
      col_term_q <= col_term;
      row_term_q <= row_term;
      ax_q       <= coef_a * point_x_q;
      by_q       <= coef_b * point_y_q;
      cx_q       <= coef_c * point_x_q;
      dy_q       <= coef_d * point_y_q;
    end
    if (state_q == ST_MUL) begin
      col_prod_q <= col_term_q * $signed({1'b0, width_q});
      row_prod_q <= row_term_q * $signed({1'b0, height_q});
    end
  end

  // Pixel dividers: (term * size) >> F divided by the span constant
  bfifs_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (PIXEL_BITS),
    .DEN   (COL_DEN)
  ) u_col_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (col_prod_q[MULT_W-1:FRAC_BITS]),
    .done_o     (col_done),
    .quot_o     (col_q),
    .ovf_o      (col_ovf)
  );

  bfifs_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (PIXEL_BITS),
    .DEN   (ROW_DEN)
  ) u_row_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (row_prod_q[MULT_W-1:FRAC_BITS]),
    .done_o     (row_done),
    .quot_o     (row_q),
    .ovf_o      (row_ovf)
  );

  assign col_o = pix_clip(width_q, col_prod_q[MULT_W-1], col_ovf, col_q);
  assign row_o = pix_clip(height_q, row_prod_q[MULT_W-1], row_ovf, row_q);
  assign idx_o = idx_q;

endmodule

FILE: design/barnsley_fern_ifs_point_generator_top.sv
// Fern point generator, chaos game style. Each random sample pushed in yields one result
// holding the screen pixel of the current point (column, row) and the index of the map
// then applied to move the point. Samples enter a two-entry queue at once; the back end
// takes one at a time and handles each point in these steps, in order: taking the index, the
// coefficient and screen-term multiplies, the screen-size multiply with the point update,
// the reciprocal multiply of the two pixel dividers, and the push of the result. Results
// wait in a two-entry output queue until popped. Screen width and height registers may
// be rewritten only while no point is in flight.
module barnsley_fern_ifs_point_generator_top import bfifs_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int PIXEL_BITS  = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] random_sample_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [PIXEL_BITS-1:0]  pixel_column_o,
  output logic [PIXEL_BITS-1:0]  pixel_row_o,
  output logic [1:0]             map_index_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i
);

  localparam int RES_W = 2 * PIXEL_BITS + 2;

  logic                  cq_wr, cq_full, cq_empty, cq_rd;
  map_e                  front_idx;
  logic [1:0]            cq_rdata;
  logic                  oq_push, oq_full;
  logic [PIXEL_BITS-1:0] back_col, back_row;
  map_e                  back_idx;
  logic [RES_W-1:0]      oq_wdata, oq_rdata;

  // Front end: accept and classify samples
  bfifs_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .push_i    (push),
    .sample_i  (random_sample_i),
    .cq_full_i (cq_full),
    .full_o    (full),
    .cq_wr_o   (cq_wr),
    .idx_o     (front_idx)
  );

  // Map index queue between front and back
  bfifs_fifo #(
    .WIDTH (2),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cq_wr),
    .wdata_i (front_idx),
    .full_o  (cq_full),
    .rd_i    (cq_rd),
    .rdata_o (cq_rdata),
    .empty_o (cq_empty)
  );

  // Back end: pixel mapping and point update
  bfifs_back #(
    .FRAC_BITS  (FRAC_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_e'(cfg_addr_i)),
    .cfg_wdata_i (cfg_wdata_i),
    .cq_empty_i  (cq_empty),
    .cq_idx_i    (map_e'(cq_rdata)),
    .cq_pop_o    (cq_rd),
    .oq_full_i   (oq_full),
    .oq_push_o   (oq_push),
    .col_o       (back_col),
    .row_o       (back_row),
    .idx_o       (back_idx)
  );

  assign oq_wdata = {back_col, back_row, back_idx};

  // Result queue
  bfifs_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (oq_push),
    .wdata_i (oq_wdata),
    .full_o  (oq_full),
    .rd_i    (pop),
    .rdata_o (oq_rdata),
    .empty_o (empty)
  );

  assign pixel_column_o = oq_rdata[RES_W-1 -: PIXEL_BITS];
  assign pixel_row_o    = oq_rdata[PIXEL_BITS+1:2];
  assign map_index_o    = oq_rdata[1:0];

  // Back end never pushes a result into a full queue
  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push |-> !oq_full)
    else $error("result pushed into full queue");

  // Front end never writes a full command queue
  a_cmd_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_wr |-> !cq_full)
    else $error("command written into full queue");

  // A pushed result is visible the next cycle
  a_res_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oq_push |=> !empty)
    else $error("result lost after push");

endmodule

FILE: sim/tb_barnsley_fern_ifs_point_generator_top.sv
`timescale 1ns / 100ps

module tb_barnsley_fern_ifs_point_generator_top;
  import bfifs_pkg::*;

  localparam int FRAC_BITS   = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int PIXEL_BITS  = 12;
  localparam int POINT_BITS  = FRAC_BITS + 8;
  // enough for the back end to finish its last point, with margin to settle
  localparam int SETTLE_CYCLES = 5 + 20;
  localparam int MAX_PRINTS    = 60;

  // Sample boundaries of the four maps
  localparam int STEM_LAST  = 655;
  localparam int FROND_LAST = 56360;
  localparam int LEFT_LAST  = 60948;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] column;
    logic [PIXEL_BITS-1:0] row;
    map_e                  map_sel;
  } pixel_txn_t;

  // DUT signals, all inputs known from time zero
  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   push            = 1'b0;
  logic                   full;
  logic [SAMPLE_BITS-1:0] random_sample_i = '0;
  logic                   empty;
  logic                   pop             = 1'b0;
  logic [PIXEL_BITS-1:0]  pixel_column_o;
  logic [PIXEL_BITS-1:0]  pixel_row_o;
  logic [1:0]             map_index_o;
  logic                   cfg_we_i        = 1'b0;
  cfg_addr_e              cfg_addr_i      = CFG_SCREEN_WIDTH;
  logic [CFG_W-1:0]       cfg_wdata_i     = '0;

  // Testbench bookkeeping
  logic [SAMPLE_BITS-1:0] sample_q[$];
  pixel_txn_t             pixel_fifo[$];
  logic                   push_taken      = 1'b0;
  int                     send_idle_pct   = 0;
  int                     recv_idle_pct   = 0;
  int                     n_errors        = 0;
  int                     n_samples       = 0;
  int                     n_pixels        = 0;
  int                     n_settings      = 1;
  int                     map_count[4]    = '{0, 0, 0, 0};

  // Predictor state: fern point and screen size
  logic signed [POINT_BITS-1:0] fern_x = '0;
  logic signed [POINT_BITS-1:0] fern_y = '0;
  int unsigned                  scr_w  = 500;
  int unsigned                  scr_h  = 500;

  // Map coefficients in hundredths: a, b, c, d, y offset
  int map_coef[4][5] = '{
    '{  0,   0,  0, 16,   0},
    '{ 85,   4, -4, 85, 160},
    '{ 20, -26, 23, 22, 160},
    '{-15,  28, 26, 24,  44}
  };

  barnsley_fern_ifs_point_generator_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .random_sample_i(random_sample_i),
    .empty          (empty),
    .pop            (pop),
    .pixel_column_o (pixel_column_o),
    .pixel_row_o    (pixel_row_o),
    .map_index_o    (map_index_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // 100 MHz clock
  always begin
    #5;
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
  end

  // Hundredths to Q.F, rounded to nearest
  function automatic longint q_of_hundredths(int h);
    longint mag;
    longint v;
    mag = (h < 0) ? -longint'(h) : longint'(h);
    v = ((mag <<< FRAC_BITS) + 50) / 100;
    return (h < 0) ? -v : v;
  endfunction

  // One coordinate of an affine map: round Q.2F to Q.F, add offset, saturate
  function automatic longint affine_coord(int ha, int hb, int hoff);
    longint acc;
    longint hi;
    longint lo;
    hi  = (longint'(1) <<< (POINT_BITS - 1)) - 1;
    lo  = -(longint'(1) <<< (POINT_BITS - 1));
    acc = q_of_hundredths(ha) * longint'(fern_x) + q_of_hundredths(hb) * longint'(fern_y);
    acc = ((acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS) + q_of_hundredths(hoff);
    if (acc > hi) acc = hi;
    else if (acc < lo) acc = lo;
    return acc;
  endfunction

  // Truncated quotient clamped to the screen and the pixel width
  function automatic logic [PIXEL_BITS-1:0] screen_coord(longint num, longint den,
                                                         int unsigned size);
    longint lim;
    longint q;
    if (size == 0 || num < 0) return '0;
    lim = longint'(size) - 1;
    if (lim > (longint'(1) <<< PIXEL_BITS) - 1) lim = (longint'(1) <<< PIXEL_BITS) - 1;
    q = num / den;
    if (q > lim) q = lim;
    return q[PIXEL_BITS-1:0];
  endfunction

  // Pixel of the current point, then one chaos game step
  function automatic pixel_txn_t fern_step(logic [SAMPLE_BITS-1:0] sample);
    pixel_txn_t res;
    longint     one;
    longint     scale;
    longint     num;
    longint     scaled;
    longint     nx;
    longint     ny;
    int         m;
    one   = longint'(1) <<< FRAC_BITS;
    scale = longint'(1) <<< SAMPLE_BITS;
    num = (longint'(fern_x) * 10000 + 21820 * one) * longint'(scr_w);
    res.column = screen_coord(num, 48378 * one, scr_w);
    num = (99983 * one - longint'(fern_y) * 10000) * longint'(scr_h);
    res.row = screen_coord(num, 99983 * one, scr_h);
    scaled = longint'(sample) * 100;
    if (scaled < scale) res.map_sel = MAP_STEM;
    else if (scaled < 86 * scale) res.map_sel = MAP_FROND;
    else if (scaled < 93 * scale) res.map_sel = MAP_LEFT;
    else res.map_sel = MAP_RIGHT;
    m  = int'(res.map_sel);
    nx = affine_coord(map_coef[m][0], map_coef[m][1], 0);
    ny = affine_coord(map_coef[m][2], map_coef[m][3], map_coef[m][4]);
    fern_x = nx[POINT_BITS-1:0];
    fern_y = ny[POINT_BITS-1:0];
    map_count[m]++;
    return res;
  endfunction

  task automatic report_error(string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // Input driver: offers the next queued sample and holds it until taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else if (!push || push_taken) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        random_sample_i <= sample_q.pop_front();
      end else begin
        push <= 1'b0;
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each accepted sample, check each popped pixel
  always @(posedge clk_i) begin
    pixel_txn_t want;
    push_taken <= rst_ni && push && !full;
    if (rst_ni) begin
      if (push && !full) begin
        pixel_fifo.push_back(fern_step(random_sample_i));
        n_samples++;
      end
      if (pop && !empty) begin
        n_pixels++;
        if (pixel_fifo.size() == 0) begin
          report_error($sformatf("unexpected result col %0d row %0d map %0d",
                                 pixel_column_o, pixel_row_o, map_index_o));
        end else begin
          want = pixel_fifo.pop_front();
          if (pixel_column_o !== want.column)
            report_error($sformatf("pixel_column got %0d expected %0d",
                                   pixel_column_o, want.column));
          if (pixel_row_o !== want.row)
            report_error($sformatf("pixel_row got %0d expected %0d",
                                   pixel_row_o, want.row));
          if (map_index_o !== want.map_sel)
            report_error($sformatf("map_index got %0d expected %0d",
                                   map_index_o, want.map_sel));
        end
      end
    end
  end

  // Register write, only while the block is idle
  task automatic write_screen(cfg_addr_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SCREEN_WIDTH) scr_w = value & 32'h1FFF;
    else scr_h = value & 32'h1FFF;
  endtask

  task automatic set_screen(int unsigned w, int unsigned h);
    write_screen(CFG_SCREEN_WIDTH, w);
    write_screen(CFG_SCREEN_HEIGHT, h);
    n_settings++;
  endtask

  // Wait until every queued sample is taken and every result has come
  task automatic drain();
    while (sample_q.size() != 0 || push || pixel_fifo.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // 0: sender light, receiver heavy; 1: the reverse; 2: no idling
  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle_pct = 38;
        recv_idle_pct = 78;
      end
      1: begin
        send_idle_pct = 78;
        recv_idle_pct = 38;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // Uniform samples, with occasional bursts inside one map to push the point far
  task automatic queue_random(int n);
    int left;
    int burst;
    int lo;
    int hi;
    left = n;
    while (left > 0) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: begin
            lo = 0;
            hi = STEM_LAST;
          end
          1: begin
            lo = STEM_LAST + 1;
            hi = FROND_LAST;
          end
          2: begin
            lo = FROND_LAST + 1;
            hi = LEFT_LAST;
          end
          default: begin
            lo = LEFT_LAST + 1;
            hi = 65535;
          end
        endcase
        burst = $urandom_range(10, 4);
        if (burst > left) burst = left;
        repeat (burst) sample_q.push_back(SAMPLE_BITS'($urandom_range(hi, lo)));
        left -= burst;
      end else begin
        sample_q.push_back(SAMPLE_BITS'($urandom_range(65535)));
        left--;
      end
    end
  endtask

  // Stimulus sequence
  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: map boundaries and field extremes at the reset screen size
    set_idling(0);
    sample_q.push_back(16'd0);
    sample_q.push_back(16'(STEM_LAST));
    sample_q.push_back(16'(STEM_LAST + 1));
    sample_q.push_back(16'(FROND_LAST));
    sample_q.push_back(16'(FROND_LAST + 1));
    sample_q.push_back(16'(LEFT_LAST));
    sample_q.push_back(16'(LEFT_LAST + 1));
    sample_q.push_back(16'hFFFF);
    sample_q.push_back(16'h5555);
    sample_q.push_back(16'hAAAA);
    // long frond run climbs toward the top row
    repeat (10) sample_q.push_back(16'd30000);
    repeat (3) sample_q.push_back(16'hFFFF);
    repeat (2) sample_q.push_back(16'd0);
    drain();

    // One-pixel screen: everything clamps to zero
    set_screen(1, 1);
    queue_random(80);
    drain();

    // Largest in-range screen, with a full drain in the middle
    set_screen(4096, 4096);
    queue_random(40);
    drain();
    queue_random(40);
    drain();

    // Zero sizes and sizes past the pixel range
    set_idling(1);
    set_screen(0, 8191);
    queue_random(60);
    drain();
    set_screen(8191, 0);
    queue_random(60);
    drain();

    set_idling(2);
    set_screen(4095, 640);
    queue_random(60);
    drain();
    set_screen($urandom_range(4096, 1), $urandom_range(4096, 1));
    queue_random(60);
    drain();

    $display("Summary: %0d samples in, %0d pixels out over %0d screen sizes",
             n_samples, n_pixels, n_settings);
    $display("Maps used: stem %0d, frond %0d, left %0d, right %0d",
             map_count[0], map_count[1], map_count[2], map_count[3]);
    if (n_errors == 0 && pixel_fifo.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("TIMEOUT: %0d results still outstanding", pixel_fifo.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
